// ----- src/median_filter_3x3_top_assert.svh -----
// Assertion macros shared by the median filter modules.
`ifndef MEDIAN_FILTER_3X3_TOP_ASSERT_SVH
`define MEDIAN_FILTER_3X3_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MF3_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("median filter assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MF3_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("median filter assertion failed");

`endif

// ----- src/mf3_pkg.sv -----
// Constants, types and compare functions of the 3x3 median filter.
package mf3_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int PIXEL_BITS     = 8;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int REG_BITS       = 11;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [REG_BITS-1:0] SIZE_RESET = 11'd1024;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam int FIFO_DEPTH     = 8;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   // One window column, sorted on entry.
   typedef struct packed {
      pixel_type lo;
      pixel_type md;
      pixel_type hi;
   } column_type;

   // What the window stage hands to the median stage.
   typedef struct packed {
      logic valid;
      logic emit_mid;
      logic emit_last;
      logic frame_end;
   } result_ctl_type;

   typedef struct packed {
      pixel_type median;
      logic      row_end;
      logic      frame_end;
   } result_type;

   function automatic pixel_type max2(input pixel_type a, input pixel_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pixel_type min2(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pixel_type med3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic column_type sort3(input pixel_type a, input pixel_type b,
                                        input pixel_type c);
      column_type r;
      r.lo = min2(min2(a, b), c);
      r.md = med3(a, b, c);
      r.hi = max2(max2(a, b), c);
      return r;
   endfunction

endpackage

// ----- src/mf3_if.sv -----
// Valid/ready stream interfaces for the pixel and result channels.
interface mf3_req_if;
   import mf3_pkg::*;
   logic      valid;
   logic      ready;
   logic      op;
   pixel_type pixel;

   modport source (output valid, output op, output pixel, input ready);
   modport sink (input valid, input op, input pixel, output ready);
endinterface

interface mf3_rsp_if;
   import mf3_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type median;
   logic      row_end;
   logic      frame_end;

   modport source (output valid, output median, output row_end, output frame_end,
                   input ready);
   modport sink (input valid, input median, input row_end, input frame_end,
                 output ready);
endinterface

// ----- src/mf3_ram.sv -----
// Generic single write port RAM with registered read.
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- src/mf3_front.sv -----
// Raster counters, line stores, column sort and the sliding window.
`include "median_filter_3x3_top_assert.svh"

module mf3_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic                             op,
   input  mf3_pkg::pixel_type               pixel,
   input  logic [mf3_pkg::REG_BITS-1:0]     image_width,
   input  logic [mf3_pkg::REG_BITS-1:0]     image_height,
   output logic                             s1_busy,
   output mf3_pkg::result_ctl_type          ctl,
   output mf3_pkg::column_type [2:0]        window
);
   import mf3_pkg::*;

   logic [REG_BITS-1:0] eff_w;
   logic [REG_BITS-1:0] eff_h;
   logic [COL_BITS-1:0] column_count_ff, column_count_in;
   logic [REG_BITS-1:0] row_count_ff, row_count_in;
   logic [COL_BITS-1:0] col;
   logic [COL_BITS:0]   col_plus;
   logic                last, drain, live, first_row;

   logic                s1_valid_ff, s1_fwd_ff;
   logic [COL_BITS-1:0] s1_addr_ff;
   logic                s1_drain_ff, s1_first_ff, s1_last_ff, s1_edge_ff;
   pixel_type           s1_pix_ff, s1_fwd_older_ff, s1_fwd_newer_ff;

   pixel_type           older_rd, newer_rd;
   pixel_type           s1_top, s1_mid, s1_bot;
   pixel_type           older_wd, newer_wd;
   logic                wr_en, fwd_in;
   column_type          new_col;

   column_type [2:0]    window_ff, window_in;
   result_ctl_type      ctl_ff, ctl_in;

   always_comb begin
      if (image_width == '0) begin
         eff_w = REG_BITS'(1);
      end else if (image_width > REG_BITS'(MAX_WIDTH)) begin
         eff_w = REG_BITS'(MAX_WIDTH);
      end else begin
         eff_w = image_width;
      end
      eff_h = (image_height == '0) ? REG_BITS'(1) : image_height;
   end

   assign col       = column_count_ff;
   assign col_plus  = {1'b0, col} + (COL_BITS + 1)'(1);
   assign last      = REG_BITS'(col_plus) >= eff_w;
   assign drain     = row_count_ff >= eff_h;
   // A flush item while rows are still expected is dropped on the spot.
   assign live      = accept && (drain || (op == OP_PIXEL));
   assign first_row = !drain && (row_count_ff == '0);

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (live) begin
         if (last) begin
            column_count_in = '0;
            if (drain) begin
               row_count_in = '0;
            end else begin
               row_count_in = row_count_ff + REG_BITS'(1);
            end
         end else begin
            column_count_in = col_plus[COL_BITS-1:0];
         end
      end
   end

   // Line stores: read at acceptance, written in the following cycle. When the
   // next item reads the address being written, the write data is forwarded.
   mf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_older_row (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (older_wd),
      .rd_addr (col),
      .rd_data (older_rd)
   );

   mf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_newer_row (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (newer_wd),
      .rd_addr (col),
      .rd_data (newer_rd)
   );

   always_comb begin
      s1_top   = s1_fwd_ff ? s1_fwd_older_ff : older_rd;
      s1_mid   = s1_fwd_ff ? s1_fwd_newer_ff : newer_rd;
      s1_bot   = s1_drain_ff ? s1_mid : s1_pix_ff;
      wr_en    = s1_valid_ff && !s1_drain_ff;
      // In the first row the pixel also stands in for the row above.
      older_wd = s1_first_ff ? s1_pix_ff : s1_mid;
      newer_wd = s1_pix_ff;
      fwd_in   = live && wr_en && (s1_addr_ff == col);
      new_col  = sort3(s1_top, s1_mid, s1_bot);
   end

   always_comb begin
      window_in = window_ff;
      ctl_in    = '0;
      if (s1_valid_ff && !s1_first_ff) begin
         if (s1_edge_ff) begin
            window_in = {new_col, new_col, new_col};
         end else begin
            window_in = {new_col, window_ff[2], window_ff[1]};
         end
         ctl_in.valid     = 1'b1;
         ctl_in.emit_mid  = !s1_edge_ff;
         ctl_in.emit_last = s1_last_ff;
         ctl_in.frame_end = s1_drain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         s1_fwd_ff       <= 1'b0;
         ctl_ff          <= '0;
         window_ff       <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         s1_valid_ff     <= live;
         s1_fwd_ff       <= fwd_in;
         ctl_ff          <= ctl_in;
         window_ff       <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff      <= col;
      s1_drain_ff     <= drain;
      s1_first_ff     <= first_row;
      s1_last_ff      <= last;
      s1_edge_ff      <= (col == '0);
      s1_pix_ff       <= pixel;
      s1_fwd_older_ff <= older_wd;
      s1_fwd_newer_ff <= newer_wd;
   end

   assign s1_busy = s1_valid_ff;
   assign ctl     = ctl_ff;
   assign window  = window_ff;

   `MF3_ASSERT_NEXT(a_frame_wraps, clock, reset, live && drain && last, (row_count_ff == '0) && (column_count_ff == '0))
   `MF3_ASSERT_IMPL(a_forward_has_source, clock, reset, s1_fwd_ff, s1_valid_ff && $past(wr_en))
endmodule

// ----- src/mf3_median.sv -----
// Median of the sorted window columns for the one or two results of an item.
module mf3_median (
   input  mf3_pkg::result_ctl_type   ctl,
   input  mf3_pkg::column_type [2:0] window,
   output logic                      push_a,
   output mf3_pkg::result_type       res_a,
   output logic                      push_b,
   output mf3_pkg::result_type       res_b
);
   import mf3_pkg::*;

   // With sorted columns the median of nine is the median of the largest
   // low, the middle middle and the smallest high.
   always_comb begin
      push_a          = ctl.valid && ctl.emit_mid;
      res_a.median    = med3(max2(max2(window[0].lo, window[1].lo), window[2].lo),
                             med3(window[0].md, window[1].md, window[2].md),
                             min2(min2(window[0].hi, window[1].hi), window[2].hi));
      res_a.row_end   = 1'b0;
      res_a.frame_end = 1'b0;

      // Last column: the right column is replicated.
      push_b          = ctl.valid && ctl.emit_last;
      res_b.median    = med3(max2(window[1].lo, window[2].lo), window[2].md,
                             min2(window[1].hi, window[2].hi));
      res_b.row_end   = 1'b1;
      res_b.frame_end = ctl.frame_end;
   end
endmodule

// ----- src/mf3_result_fifo.sv -----
// Result queue taking up to two items per cycle and giving one.
`include "median_filter_3x3_top_assert.svh"

module mf3_result_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push_a,
   input  mf3_pkg::result_type                 res_a,
   input  logic                                push_b,
   input  mf3_pkg::result_type                 res_b,
   input  logic                                pop,
   output logic [mf3_pkg::FIFO_CNT_BITS-1:0]   count,
   output mf3_pkg::result_type                 head
);
   import mf3_pkg::*;

   result_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_b_ptr;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in, push_n;

   always_comb begin
      push_n    = FIFO_CNT_BITS'(push_a) + FIFO_CNT_BITS'(push_b);
      wr_b_ptr  = wr_ptr_ff + FIFO_PTR_BITS'(push_a);
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_BITS'(push_n);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_BITS'(pop);
      count_in  = count_ff + push_n - FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         mem_ff[wr_ptr_ff] <= res_a;
      end
      if (push_b) begin
         mem_ff[wr_b_ptr] <= res_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign count = count_ff;
   assign head  = mem_ff[rd_ptr_ff];

   `MF3_ASSERT_IMPL(a_no_overflow, clock, reset, push_a || push_b, (count_ff + push_n) <= (FIFO_CNT_BITS'(FIFO_DEPTH) + FIFO_CNT_BITS'(pop)))
   `MF3_ASSERT_IMPL(a_frame_end_closes_row, clock, reset, (count_ff != '0) && head.frame_end, head.row_end)
endmodule

// ----- src/median_filter_3x3_top.sv -----
// Channel   Direction  Contents
// req_chan  in         op, pixel (raster order, flush items after the frame)
// rsp_chan  out        median, row_end, frame_end
// csr_*     in         image_width (index 0), image_height (index 1)
//
// One item is taken per cycle while ready is high; an item's results reach
// rsp_chan through the line store read, registered at the accepting edge, then
// the window register and the result queue. Ready drops only when the
// eight-entry result queue cannot hold the results still in flight.
// Synchronous reset clears counters, window and queue; the line stores hold no
// reset state.
module median_filter_3x3_top (
   input  logic                                clock,
   input  logic                                reset,
   mf3_req_if.sink                             req_chan,
   mf3_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [mf3_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mf3_pkg::REG_BITS-1:0]        csr_wdata
);
   import mf3_pkg::*;

   logic [REG_BITS-1:0]      image_width_ff, image_width_in;
   logic [REG_BITS-1:0]      image_height_ff, image_height_in;
   logic                     accept, ready, pop, s1_busy;
   logic                     push_a, push_b;
   result_type               res_a, res_b, head;
   result_ctl_type           ctl;
   column_type [2:0]         window;
   logic [FIFO_CNT_BITS-1:0] count;
   logic [FIFO_CNT_BITS:0]   credit;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               image_width_in = csr_wdata;
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= SIZE_RESET;
         image_height_ff <= SIZE_RESET;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   // Each item in flight may still add two results to the queue.
   always_comb begin
      credit = {1'b0, count}
             + (s1_busy   ? (FIFO_CNT_BITS + 1)'(2) : '0)
             + (ctl.valid ? (FIFO_CNT_BITS + 1)'(2) : '0);
      ready  = credit <= (FIFO_CNT_BITS + 1)'(FIFO_DEPTH - 2);
   end

   assign req_chan.ready = ready;
   assign accept         = req_chan.valid && ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   mf3_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .op           (req_chan.op),
      .pixel        (req_chan.pixel),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .s1_busy      (s1_busy),
      .ctl          (ctl),
      .window       (window)
   );

   mf3_median u_median (
      .ctl    (ctl),
      .window (window),
      .push_a (push_a),
      .res_a  (res_a),
      .push_b (push_b),
      .res_b  (res_b)
   );

   mf3_result_fifo u_result_fifo (
      .clock  (clock),
      .reset  (reset),
      .push_a (push_a),
      .res_a  (res_a),
      .push_b (push_b),
      .res_b  (res_b),
      .pop    (pop),
      .count  (count),
      .head   (head)
   );

   assign rsp_chan.valid     = (count != '0);
   assign rsp_chan.median    = head.median;
   assign rsp_chan.row_end   = head.row_end;
   assign rsp_chan.frame_end = head.frame_end;
endmodule

// ----- tb/median_filter_3x3_checker.sv -----
`timescale 1ns / 100ps
// Checker for the 3x3 median filter: predicts every result and compares it with the block.
module median_filter_3x3_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_op,
   input  mf3_pkg::pixel_type                 req_pixel,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  mf3_pkg::pixel_type                 rsp_median,
   input  logic                               rsp_row_end,
   input  logic                               rsp_frame_end,
   input  logic                               csr_we,
   input  logic [mf3_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mf3_pkg::REG_BITS-1:0]       csr_wdata,
   output int unsigned                        mismatch_count,
   output int unsigned                        outstanding
);
   import mf3_pkg::*;

   localparam int MEDIAN_RANK = 4;

   pixel_type          prev2_row [MAX_WIDTH];
   pixel_type          prev1_row [MAX_WIDTH];
   // Window columns left to right, each holding the top, middle and bottom value.
   pixel_type          win [3][3];
   int unsigned        col_pos;
   int unsigned        row_pos;
   logic [REG_BITS-1:0] img_width;
   logic [REG_BITS-1:0] img_height;
   result_type         expected_medians [$];

   function automatic pixel_type median_of_cols(input int a, input int b, input int c);
      pixel_type v [9];
      pixel_type x;
      int        j;
      for (int i = 0; i < 3; i++) begin
         v[i] = win[a][i];
         v[3 + i] = win[b][i];
         v[6 + i] = win[c][i];
      end
      for (int i = 1; i < 9; i++) begin
         x = v[i];
         j = i - 1;
         while (j >= 0 && v[j] > x) begin
            v[j + 1] = v[j];
            j--;
         end
         v[j + 1] = x;
      end
      return v[MEDIAN_RANK];
   endfunction

   function automatic void add_expected(input result_type r);
      expected_medians.insert(expected_medians.size(), r);
   endfunction

   task automatic predict_medians(input logic op, input pixel_type pix);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      logic        drain;
      logic        last;
      pixel_type   top_px;
      pixel_type   mid_px;
      pixel_type   bot_px;
      w = (img_width == 0) ? 1 : ((img_width > MAX_WIDTH) ? MAX_WIDTH : img_width);
      h = (img_height == 0) ? 1 : img_height;
      c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
      drain = (row_pos >= h);
      last = ((c + 1) >= w);
      // A flush item is ignored while rows are still expected.
      if (!drain && op == OP_FLUSH) return;
      if (drain) begin
         top_px = prev2_row[c];
         mid_px = prev1_row[c];
         bot_px = mid_px;
      end else begin
         if (row_pos == 0) begin
            // The first row stands in for the row above itself.
            prev2_row[c] = pix;
            prev1_row[c] = pix;
            if (last) begin
               col_pos = 0;
               row_pos++;
            end else begin
               col_pos = c + 1;
            end
            return;
         end
         top_px = prev2_row[c];
         mid_px = prev1_row[c];
         bot_px = pix;
         prev2_row[c] = mid_px;
         prev1_row[c] = pix;
      end
      if (c == 0) begin
         for (int k = 0; k < 3; k++) begin
            win[k] = '{top_px, mid_px, bot_px};
         end
      end else begin
         win[0] = win[1];
         win[1] = win[2];
         win[2] = '{top_px, mid_px, bot_px};
         add_expected(result_type'{median_of_cols(0, 1, 2), 1'b0, 1'b0});
      end
      if (last) begin
         // The right neighbor of the last column is the last column itself.
         add_expected(result_type'{median_of_cols(1, 2, 2), 1'b1, drain});
         col_pos = 0;
         if (drain) row_pos = 0;
         else row_pos++;
      end else begin
         col_pos = c + 1;
      end
   endtask

   always @(posedge clock) begin : check_edge
      result_type got;
      result_type want;
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            prev2_row[i] = '0;
            prev1_row[i] = '0;
         end
         for (int k = 0; k < 3; k++) begin
            win[k] = '{default: '0};
         end
         col_pos = 0;
         row_pos = 0;
         img_width = SIZE_RESET;
         img_height = SIZE_RESET;
         expected_medians.delete();
         mismatch_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = result_type'{rsp_median, rsp_row_end, rsp_frame_end};
            if (expected_medians.size() == 0) begin
               $display("%0t: unexpected result median=%0d row_end=%0b frame_end=%0b",
                        $time, got.median, got.row_end, got.frame_end);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_medians.pop_front();
               if (got.median !== want.median || got.row_end !== want.row_end ||
                   got.frame_end !== want.frame_end) begin
                  $display("%0t: mismatch expected median=%0d row_end=%0b frame_end=%0b, %s",
                           $time, want.median, want.row_end, want.frame_end,
                           $sformatf("got median=%0d row_end=%0b frame_end=%0b",
                                     got.median, got.row_end, got.frame_end));
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_IMAGE_WIDTH) img_width = csr_wdata;
            else if (csr_index == CSR_IMAGE_HEIGHT) img_height = csr_wdata;
         end
         if (req_valid && req_ready) predict_medians(req_op, req_pixel);
      end
      outstanding <= expected_medians.size();
   end

endmodule

// ----- tb/median_filter_3x3_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the 3x3 median filter: clock, reset, pixel frames, idling and verdict.
module median_filter_3x3_top_tb;
   import mf3_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 720;
   localparam int HOLD_CYCLES = 120;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [REG_BITS-1:0]       csr_wdata = '0;
   int unsigned               mismatch_count;
   int unsigned               outstanding;
   int unsigned               quiet_cycles = 0;
   int unsigned               item_total = 0;
   int unsigned               idle_phase = 0;
   int unsigned               send_idle_pct = 34;
   int unsigned               recv_idle_pct = 56;
   int unsigned               hold_left = 0;
   bit                        hold_armed = 1'b0;
   bit                        hold_done = 1'b0;

   mf3_req_if req_chan ();
   mf3_rsp_if rsp_chan ();

   median_filter_3x3_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   median_filter_3x3_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_op         (req_chan.op),
      .req_pixel      (req_chan.pixel),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_median     (rsp_chan.median),
      .rsp_row_end    (rsp_chan.row_end),
      .rsp_frame_end  (rsp_chan.frame_end),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.op = OP_PIXEL;
      req_chan.pixel = '0;
      rsp_chan.ready = 1'b0;
   end

   // Receiver: random stalls, plus one long hold-off once the sender offers the armed frame.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done && req_chan.valid) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Offers one item and returns at the edge that accepts it; valid stays high.
   task automatic send_item(input logic op, input pixel_type pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.pixel <= pix;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_frame_size(input logic [REG_BITS-1:0] w_reg,
                                 input logic [REG_BITS-1:0] h_reg);
      wait_idle();
      // A trailing ignored item may still be in the pipeline.
      repeat (6) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w_reg;
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h_reg;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_frame(input logic [REG_BITS-1:0] w_reg, input logic [REG_BITS-1:0] h_reg);
      int unsigned w;
      int unsigned h;
      pixel_type   pix;
      w = (w_reg == 0) ? 1 : ((w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg);
      h = (h_reg == 0) ? 1 : h_reg;
      set_frame_size(w_reg, h_reg);
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            if ($urandom_range(99) < 4) send_item(OP_FLUSH, pixel_type'($urandom_range(255)));
            if ($urandom_range(7) == 0) pix = $urandom_range(1) ? 8'hFF : 8'h00;
            else pix = pixel_type'($urandom_range(255));
            send_item(OP_PIXEL, pix);
         end
      end
      // Drain row: a pixel item here acts as a flush item.
      for (int c = 0; c < w; c++) begin
         if ($urandom_range(9) == 0) send_item(OP_PIXEL, pixel_type'($urandom_range(255)));
         else send_item(OP_FLUSH, pixel_type'($urandom_range(255)));
      end
      item_total += h * w + w;
   endtask

   initial begin
      pixel_type pattern [9];
      pattern = '{8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h07, 8'hC8, 8'h00};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed 3x3 frame with extreme pixels, ignored flushes and a pixel item in the drain.
      set_frame_size(11'd3, 11'd3);
      send_item(OP_FLUSH, 8'hFF);
      for (int i = 0; i < 9; i++) begin
         if (i == 4) send_item(OP_FLUSH, 8'h55);
         send_item(OP_PIXEL, pattern[i]);
      end
      send_item(OP_PIXEL, 8'hFF);
      send_item(OP_FLUSH, 8'h00);
      send_item(OP_FLUSH, 8'hAA);
      run_frame(11'd1, 11'd1);
      run_frame(11'd0, 11'd0);
      run_frame(11'd2, 11'd1);

      item_total = 0;
      while (item_total < RANDOM_ITEMS) begin
         idle_phase = (item_total < RANDOM_ITEMS / 3) ? 0 :
                      (item_total < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
         send_idle_pct = (idle_phase == 0) ? 34 : (idle_phase == 1) ? 56 : 0;
         recv_idle_pct = (idle_phase == 0) ? 56 : (idle_phase == 1) ? 34 : 0;
         if ($urandom_range(7) == 0) begin
            run_frame(11'($urandom_range(13, 64)), 11'($urandom_range(1, 4)));
         end else begin
            run_frame(11'($urandom_range(1, 12)), 11'($urandom_range(1, 6)));
         end
      end

      // The receiver holds off while this frame streams in, so the block fills and stalls.
      idle_phase = 2;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_idle();
      hold_armed = 1'b1;
      run_frame(11'd40, 11'd3);

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/mf3_pkg.sv
src/mf3_if.sv
src/mf3_ram.sv
src/mf3_front.sv
src/mf3_median.sv
src/mf3_result_fifo.sv
src/median_filter_3x3_top.sv
tb/median_filter_3x3_checker.sv
tb/median_filter_3x3_top_tb.sv
